[rtl/core/nau_pkg.sv]
package nau_pkg;

  localparam int DATA_W        = 16;
  localparam int MODE_W        = 3;
  localparam int FRAC_BITS_DEF = 12;
  localparam int EF            = 40;
  localparam int EW            = EF + 1;
  localparam int SPL           = 20;
  localparam int PROD_W        = 36;

  typedef enum logic [MODE_W-1:0] {
    MODE_SIG    = 3'd0,
    MODE_SIG_D  = 3'd1,
    MODE_ID     = 3'd2,
    MODE_ID_D   = 3'd3,
    MODE_TANH   = 3'd4,
    MODE_TANH_D = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    SEL_SIG    = 3'b001,
    SEL_TANH   = 3'b010,
    SEL_SIMPLE = 3'b100
  } sel_t;

  typedef struct packed {
    logic                     last;
    sel_t                     sel;
    logic                     neg;
    logic                     sub;
    logic signed [PROD_W-1:0] prod;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  function automatic logic [EW-1:0] exp_fix(input real arg);
    real v;
    v = $exp(-arg) * (2.0 ** EF);
    return EW'(longint'(v));
  endfunction

endpackage

[rtl/core/neural_activation_unit_core.sv]
// Element-wise activation unit: one signed fixed-point sample per item with FRAC_BITS
// fraction bits, a mode (sigmoid, sigmoid derivative, identity, identity derivative,
// tanh, tanh derivative) and a last-of-layer flag; one rounded, saturated result per
// item with the flag passed along. Fully pipelined: a new item is taken every clock
// unless a stall at the output has backed up to the input. The pipeline is made up of
// the table lookup, two split 41-bit exponent multipliers of two stages each, the
// restoring divider at two quotient bits per stage, and the output register. Every
// stage has its own valid and stall, so bubbles close up behind a stalled output.
module neural_activation_unit_core import nau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_x_value,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic                     in_last_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_y_value,
  output logic                     out_last_out
);

  logic                lk_rdy, lk_vld, m1_rdy, m1_vld, m2_rdy, m2_vld;
  logic                dv_rdy, dv_vld, ot_rdy;
  ctl_t                lk_ctl, m2_ctl_in, m2_ctl, dv_ctl;
  logic [EW-1:0]       lk_a, lk_b, lk_c, m1_p, m1_c, m2_p;
  logic [FRAC_BITS+2:0] dv_q;

  nau_lookup #(.FRAC_BITS(FRAC_BITS)) u_lookup (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .in_rdy  (lk_rdy),
    .in_x    (in_x_value),
    .in_mode (in_mode),
    .in_last (in_last_in),
    .out_vld (lk_vld),
    .out_rdy (m1_rdy),
    .out_ctl (lk_ctl),
    .out_a   (lk_a),
    .out_b   (lk_b),
    .out_c   (lk_c)
  );

  nau_mul #(.SIDE_W(CTL_W + EW)) u_mul_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (lk_vld),
    .in_rdy   (m1_rdy),
    .in_a     (lk_a),
    .in_b     (lk_b),
    .in_side  ({lk_ctl, lk_c}),
    .out_vld  (m1_vld),
    .out_rdy  (m2_rdy),
    .out_p    (m1_p),
    .out_side ({m2_ctl_in, m1_c})
  );

  nau_mul #(.SIDE_W(CTL_W)) u_mul_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (m1_vld),
    .in_rdy   (m2_rdy),
    .in_a     (m1_p),
    .in_b     (m1_c),
    .in_side  (m2_ctl_in),
    .out_vld  (m2_vld),
    .out_rdy  (dv_rdy),
    .out_p    (m2_p),
    .out_side (m2_ctl)
  );

  nau_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(CTL_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (m2_vld),
    .in_rdy   (dv_rdy),
    .in_e     (m2_p),
    .in_side  (m2_ctl),
    .out_vld  (dv_vld),
    .out_rdy  (ot_rdy),
    .out_q    (dv_q),
    .out_side (dv_ctl)
  );

  nau_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (dv_vld),
    .in_rdy    (ot_rdy),
    .in_q      (dv_q),
    .in_ctl    (dv_ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_y     (out_y_value),
    .out_last  (out_last_out)
  );

  assign in_stall = !lk_rdy;

endmodule

[rtl/core/nau_lookup.sv]
module nau_lookup import nau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  output logic                     in_rdy,
  input  logic signed [DATA_W-1:0] in_x,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic                     in_last,
  output logic                     out_vld,
  input  logic                     out_rdy,
  output ctl_t                     out_ctl,
  output logic [EW-1:0]            out_a,
  output logic [EW-1:0]            out_b,
  output logic [EW-1:0]            out_c
);

  localparam int  UW      = DATA_W + 2;
  localparam int  NW      = UW - FRAC_BITS;
  localparam int  NEB     = (NW < 5) ? NW : 5;
  localparam int  NE      = 2 ** NEB;
  localparam int  LO_BITS = FRAC_BITS / 2;
  localparam int  HI_BITS = FRAC_BITS - LO_BITS;
  localparam real HI_STEP = 1.0 / (2.0 ** HI_BITS);
  localparam real LO_STEP = 1.0 / (2.0 ** FRAC_BITS);
  localparam logic signed [DATA_W:0]   ONE_A = (DATA_W+1)'(1) << FRAC_BITS;
  localparam logic signed [DATA_W+1:0] ONE_B = (DATA_W+2)'(1) << FRAC_BITS;

  logic [EW-1:0] en_tab [NE];
  logic [EW-1:0] hi_tab [2**HI_BITS];
  logic [EW-1:0] lo_tab [2**LO_BITS];

  for (genvar i = 0; i < NE; i++) begin : g_en
    assign en_tab[i] = exp_fix(real'(i));
  end
  for (genvar i = 0; i < 2**HI_BITS; i++) begin : g_hi
    assign hi_tab[i] = exp_fix(real'(i) * HI_STEP);
  end
  for (genvar i = 0; i < 2**LO_BITS; i++) begin : g_lo
    assign lo_tab[i] = exp_fix(real'(i) * LO_STEP);
  end

  logic signed [DATA_W:0]   x_ext;
  logic [DATA_W:0]          mag;
  logic [UW-1:0]            u;
  logic [NW-1:0]            n;
  logic                     n_big;
  logic signed [DATA_W:0]   ma;
  logic signed [DATA_W+1:0] mb;
  ctl_t                     ctl_nxt;
  logic [EW-1:0]            a_nxt;

  logic    vld_r;
  ctl_t    ctl_r;
  logic [EW-1:0] a_r, b_r, c_r;

  assign x_ext = (DATA_W+1)'(in_x);
  assign mag   = in_x[DATA_W-1] ? unsigned'(-x_ext) : unsigned'(x_ext);
  assign u     = (mode_t'(in_mode) == MODE_TANH) ? {mag, 1'b0} : {1'b0, mag};
  assign n     = u[UW-1:FRAC_BITS];

  if (NW > NEB) begin : g_big
    assign n_big = |n[NW-1:NEB];
  end else begin : g_nobig
    assign n_big = 1'b0;
  end

  assign a_nxt = n_big ? '0 : en_tab[n[NEB-1:0]];

  always_comb begin
    ma           = '0;
    mb           = '0;
    ctl_nxt.last = in_last;
    ctl_nxt.sel  = SEL_SIMPLE;
    ctl_nxt.neg  = in_x[DATA_W-1];
    ctl_nxt.sub  = 1'b0;
    case (mode_t'(in_mode))
      MODE_SIG:    ctl_nxt.sel = SEL_SIG;
      MODE_TANH:   ctl_nxt.sel = SEL_TANH;
      MODE_SIG_D: begin
        ma = x_ext;
        mb = ONE_B - (DATA_W+2)'(in_x);
      end
      MODE_ID: begin
        ma = x_ext;
        mb = ONE_B;
      end
      MODE_ID_D: begin
        ma = ONE_A;
        mb = ONE_B;
      end
      MODE_TANH_D: begin
        ma          = x_ext;
        mb          = (DATA_W+2)'(in_x);
        ctl_nxt.sub = 1'b1;
      end
      default: ;
    endcase
    ctl_nxt.prod = PROD_W'(ma) * PROD_W'(mb);
  end

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      ctl_r <= ctl_nxt;
      a_r   <= a_nxt;
      b_r   <= hi_tab[u[FRAC_BITS-1:LO_BITS]];
      c_r   <= lo_tab[u[LO_BITS-1:0]];
    end
  end

  assign out_vld = vld_r;
  assign out_ctl = ctl_r;
  assign out_a   = a_r;
  assign out_b   = b_r;
  assign out_c   = c_r;

endmodule

[rtl/core/nau_mul.sv]
module nau_mul import nau_pkg::*; #(
  parameter int SIDE_W = CTL_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  logic [EW-1:0]     in_a,
  input  logic [EW-1:0]     in_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [EW-1:0]     out_p,
  output logic [SIDE_W-1:0] out_side
);

  localparam int PHW = 2 * EW - SPL;
  localparam int PLW = EW + SPL;
  localparam int SW  = 2 * EW;

  logic              v1_r, v2_r, rdy1, rdy2;
  logic [PHW-1:0]    ph_r;
  logic [PLW-1:0]    pl_r;
  logic [SIDE_W-1:0] side1_r, side2_r;
  logic [SW-1:0]     sum;
  logic [EW-1:0]     p_r;

  assign rdy2   = !v2_r || out_rdy;
  assign rdy1   = !v1_r || rdy2;
  assign in_rdy = rdy1;
  assign sum    = (SW'(ph_r) << SPL) + SW'(pl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_vld;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ph_r    <= PHW'(in_a) * PHW'(in_b[EW-1:SPL]);
      pl_r    <= PLW'(in_a) * PLW'(in_b[SPL-1:0]);
      side1_r <= in_side;
    end
    if (rdy2) begin
      p_r     <= sum[EF +: EW];
      side2_r <= side1_r;
    end
  end

  assign out_vld  = v2_r;
  assign out_p    = p_r;
  assign out_side = side2_r;

endmodule

[rtl/core/nau_div.sv]
module nau_div import nau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = CTL_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  output logic                 in_rdy,
  input  logic [EW-1:0]        in_e,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output logic [FRAC_BITS+2:0] out_q,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int QN  = FRAC_BITS + 3;
  localparam int SPS = 2;
  localparam int NST = (QN + SPS - 1) / SPS;
  localparam int RW  = EF + 3;
  localparam int DW  = EF + 2;
  localparam logic [QN-1:0] Q_MIN = QN'(1) << (FRAC_BITS + 1);
  localparam logic [QN-1:0] Q_MAX = QN'(1) << (FRAC_BITS + 2);

  logic [NST-1:0]    vld_r, vld_src, rdy;
  logic [RW-1:0]     rem_r [NST];
  logic [RW-1:0]     rem_src [NST];
  logic [RW-1:0]     rem_nxt [NST];
  logic [QN-1:0]     q_r [NST];
  logic [QN-1:0]     q_src [NST];
  logic [QN-1:0]     q_nxt [NST];
  logic [DW-1:0]     d_r [NST];
  logic [DW-1:0]     d_src [NST];
  logic [SIDE_W-1:0] side_r [NST];
  logic [SIDE_W-1:0] side_src [NST];

  always_comb begin
    vld_src[0]  = in_vld;
    rem_src[0]  = RW'(1) << (EF - 1);
    q_src[0]    = '0;
    d_src[0]    = DW'(in_e) + (DW'(1) << EF);
    side_src[0] = in_side;
    for (int s = 1; s < NST; s++) begin
      vld_src[s]  = vld_r[s-1];
      rem_src[s]  = rem_r[s-1];
      q_src[s]    = q_r[s-1];
      d_src[s]    = d_r[s-1];
      side_src[s] = side_r[s-1];
    end
  end

  always_comb begin
    logic [RW-1:0] rem;
    logic [QN-1:0] q;
    for (int s = 0; s < NST; s++) begin
      rem = rem_src[s];
      q   = q_src[s];
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < QN) begin
          rem = rem << 1;
          if (rem >= RW'(d_src[s])) begin
            rem = rem - RW'(d_src[s]);
            q   = {q[QN-2:0], 1'b1};
          end else begin
            q   = {q[QN-2:0], 1'b0};
          end
        end
      end
      rem_nxt[s] = rem;
      q_nxt[s]   = q;
    end
  end

  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || out_rdy;
    for (int s = NST - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (rdy[s]) begin
          vld_r[s] <= vld_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NST; s++) begin
      if (rdy[s]) begin
        rem_r[s]  <= rem_nxt[s];
        q_r[s]    <= q_nxt[s];
        d_r[s]    <= d_src[s];
        side_r[s] <= side_src[s];
      end
    end
  end

  assign in_rdy   = rdy[0];
  assign out_vld  = vld_r[NST-1];
  assign out_q    = q_r[NST-1];
  assign out_side = side_r[NST-1];

  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] |-> (q_r[NST-1] >= Q_MIN) && (q_r[NST-1] <= Q_MAX))
    else $error("quotient out of range");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] |-> rem_r[NST-1] < RW'(d_r[NST-1]))
    else $error("remainder not below divisor");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] && !out_rdy |=> vld_r[NST-1] && $stable(q_r[NST-1])
      && $stable(side_r[NST-1]))
    else $error("stalled quotient lost");

endmodule

[rtl/core/nau_out.sv]
module nau_out import nau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  output logic                     in_rdy,
  input  logic [FRAC_BITS+2:0]     in_q,
  input  ctl_t                     in_ctl,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_y,
  output logic                     out_last
);

  localparam int YW = PROD_W + 1;
  localparam logic signed [YW-1:0] ONE_Y  = YW'(1) << FRAC_BITS;
  localparam logic signed [YW-1:0] HALF_Y = YW'(1) << (FRAC_BITS - 1);
  localparam logic signed [YW-1:0] Y_MAX  = YW'(32767);
  localparam logic signed [YW-1:0] Y_MIN  = YW'(-32768);

  logic signed [YW-1:0]     qv, v_sig, v_tanh, r, y;
  logic signed [DATA_W-1:0] y_nxt;
  logic                     vld_r, last_r;
  logic signed [DATA_W-1:0] y_r;

  assign qv     = signed'(YW'(in_q));
  assign v_sig  = ((qv >>> 1) + YW'(1)) >>> 1;
  assign v_tanh = ((qv + YW'(1)) >>> 1) - ONE_Y;
  assign r      = (YW'(in_ctl.prod) + HALF_Y) >>> FRAC_BITS;

  always_comb begin
    case (in_ctl.sel)
      SEL_SIG:    y = in_ctl.neg ? ONE_Y - v_sig : v_sig;
      SEL_TANH:   y = in_ctl.neg ? -v_tanh : v_tanh;
      SEL_SIMPLE: y = in_ctl.sub ? ONE_Y - r : r;
      default:    y = '0;
    endcase
    if (y > Y_MAX) begin
      y_nxt = Y_MAX[DATA_W-1:0];
    end else if (y < Y_MIN) begin
      y_nxt = Y_MIN[DATA_W-1:0];
    end else begin
      y_nxt = y[DATA_W-1:0];
    end
  end

  assign in_rdy = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      y_r    <= y_nxt;
      last_r <= in_ctl.last;
    end
  end

  assign out_valid = vld_r;
  assign out_y     = y_r;
  assign out_last  = last_r;

endmodule
